// File: rtl/vacs_pkg.sv
package vacs_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;

    localparam logic [1:0] REG_BOX_WIDTH  = 2'd0;
    localparam logic [1:0] REG_BOX_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRAV_ACCEL = 2'd2;
    localparam logic [1:0] REG_GRAV_ON    = 2'd3;

    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture input item
        logic       do_write;  // write one voxel
        logic       do_set;    // set position
        logic       grav;      // apply gravity to vy
        logic       amt;       // register move amount for current axis
        logic       range;     // register voxel range of box moved along current axis
        logic       scan_init; // reset scan indices
        logic       scan_step; // visit one voxel
        logic       commit;    // commit axis result
        logic [1:0] axis;
        logic       clr_step;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic amt_zero;
        logic range_empty;
        logic scan_last;
        logic clr_last;
    } t_status;

    function automatic logic signed [23:0] sat24(input logic signed [41:0] v);
        if (v > 42'sd8388607) begin
            return POS_MAX;
        end else if (v < -42'sd8388608) begin
            return POS_MIN;
        end else begin
            return v[23:0];
        end
    endfunction

endpackage

// File: rtl/voxel_aabb_collision_step.sv
// Write, set and unused actions pass through decode and output; a tick adds gravity
// and, per axis, the move amount, range, scan set-up, voxel scan and commit, stopping
// after the move amount for a zero move and skipping the scan for an empty range.
// Throughput: one item at a time; next item accepted the cycle after the result transfers.
// Reset (synchronous, active low) clears control and then sweeps the occupancy
// memory, one voxel per cycle, over all 2^(GRID_X_BITS+GRID_Y_BITS+GRID_Z_BITS) voxels.
module voxel_aabb_collision_step
    import vacs_pkg::*;
#(
    parameter int GRID_X_BITS = 6,
    parameter int GRID_Y_BITS = 6,
    parameter int GRID_Z_BITS = 6
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic signed [23:0] i_coord_x,
    input  logic signed [23:0] i_coord_y,
    input  logic signed [23:0] i_coord_z,
    input  logic               i_solid,
    input  logic signed [23:0] i_vel_in_x,
    input  logic signed [23:0] i_vel_in_y,
    input  logic signed [23:0] i_vel_in_z,
    input  logic [15:0]        i_time_step,
    input  logic               i_clear_ground,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_pos_x,
    output logic signed [23:0] o_pos_y,
    output logic signed [23:0] o_pos_z,
    output logic signed [23:0] o_vel_out_x,
    output logic signed [23:0] o_vel_out_y,
    output logic signed [23:0] o_vel_out_z,
    output logic               o_on_ground,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    logic [9:0]  r_box_width;
    logic [10:0] r_box_height;
    logic [15:0] r_gravity_accel;
    logic        r_gravity_on;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width     <= 10'd154;
            r_box_height    <= 11'd461;
            r_gravity_accel <= 16'd8192;
            r_gravity_on    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BOX_WIDTH:  r_box_width     <= i_cfg_data[9:0];
                REG_BOX_HEIGHT: r_box_height    <= i_cfg_data[10:0];
                REG_GRAV_ACCEL: r_gravity_accel <= i_cfg_data;
                REG_GRAV_ON:    r_gravity_on    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    t_cmd    cmd;
    t_status status;

    vacs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    vacs_dp #(
        .GX (GRID_X_BITS),
        .GY (GRID_Y_BITS),
        .GZ (GRID_Z_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_action        (i_action),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_solid         (i_solid),
        .i_vel_in_x      (i_vel_in_x),
        .i_vel_in_y      (i_vel_in_y),
        .i_vel_in_z      (i_vel_in_z),
        .i_time_step     (i_time_step),
        .i_clear_ground  (i_clear_ground),
        .i_rst_n         (i_rst_n),
        .i_box_width     (r_box_width),
        .i_box_height    (r_box_height),
        .i_gravity_accel (r_gravity_accel),
        .i_gravity_on    (r_gravity_on),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_vel_out_x     (o_vel_out_x),
        .o_vel_out_y     (o_vel_out_y),
        .o_vel_out_z     (o_vel_out_z),
        .o_on_ground     (o_on_ground)
    );

endmodule

// File: rtl/vacs_ctrl.sv
module vacs_ctrl
    import vacs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    output logic       o_valid,
    input  logic       i_ready,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_GRAV  = 4'd3;
    localparam logic [3:0] S_AMT   = 4'd4;
    localparam logic [3:0] S_RANGE = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_COMM  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic [1:0] r_act;
    logic       r_out_valid, n_out_valid;

    // one result register: a new item may not enter until it has gone
    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (r_act == ACT_WRITE) begin
                    o_cmd.do_write = 1'b1;
                    n_state        = S_OUT;
                end else if (r_act == ACT_SET) begin
                    o_cmd.do_set = 1'b1;
                    n_state      = S_OUT;
                end else if (r_act == ACT_TICK) begin
                    n_state = S_GRAV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_GRAV: begin
                o_cmd.grav = 1'b1;
                n_axis     = 2'd0;
                n_state    = S_AMT;
            end
            S_AMT: begin
                o_cmd.amt = 1'b1;
                n_state   = S_RANGE;
            end
            S_RANGE: begin
                if (i_status.amt_zero) begin
                    n_state = (r_axis == 2'd2) ? S_OUT : S_AMT;
                    n_axis  = r_axis + 2'd1;
                end else begin
                    o_cmd.range = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.scan_init = 1'b1;
                n_state         = i_status.range_empty ? S_COMM : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) n_state = S_COMM;
            end
            S_COMM: begin
                o_cmd.commit = 1'b1;
                n_state      = (r_axis == 2'd2) ? S_OUT : S_AMT;
                n_axis       = r_axis + 2'd1;
            end
            S_OUT: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_axis      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
        if (o_cmd.load) r_act <= i_action;
    end

    a_out_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_IDLE || r_state == S_DEC || r_state == S_CLEAR
                         || r_state == S_OUT || r_state == S_GRAV || r_state == S_AMT
                         || r_state == S_RANGE || r_state == S_CHK || r_state == S_SCAN
                         || r_state == S_COMM) && !o_ready)
        else $error("ready while result pending");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DEC))
        else $error("load did not start decode");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_out_valid)
        else $error("result not raised");
    a_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (r_axis != 2'd3))
        else $error("bad axis");

endmodule

// File: rtl/vacs_dp.sv
module vacs_dp
    import vacs_pkg::*;
#(
    parameter int GX = 6,
    parameter int GY = 6,
    parameter int GZ = 6
)(
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [1:0]         i_action,
    input  logic signed [23:0] i_coord_x,
    input  logic signed [23:0] i_coord_y,
    input  logic signed [23:0] i_coord_z,
    input  logic               i_solid,
    input  logic signed [23:0] i_vel_in_x,
    input  logic signed [23:0] i_vel_in_y,
    input  logic signed [23:0] i_vel_in_z,
    input  logic [15:0]        i_time_step,
    input  logic               i_clear_ground,
    input  logic               i_rst_n,
    input  logic [9:0]         i_box_width,
    input  logic [10:0]        i_box_height,
    input  logic [15:0]        i_gravity_accel,
    input  logic               i_gravity_on,
    output logic signed [23:0] o_pos_x,
    output logic signed [23:0] o_pos_y,
    output logic signed [23:0] o_pos_z,
    output logic signed [23:0] o_vel_out_x,
    output logic signed [23:0] o_vel_out_y,
    output logic signed [23:0] o_vel_out_z,
    output logic               o_on_ground
);

    localparam int AW = GX + GY + GZ;
    localparam int DEPTH = 1 << AW;

    logic mem [DEPTH];

    logic signed [23:0] r_pos [3];
    logic signed [23:0] r_vel [3];
    logic               r_grounded;
    logic signed [23:0] r_cin [3];
    logic               r_solid_in, r_clr_g;
    logic [15:0]        r_ts;
    logic [AW-1:0]      r_clr_addr;

    logic signed [41:0] r_amt;     // move amount for current axis
    logic signed [41:0] r_corr;
    logic               r_hit;
    logic signed [25:0] r_lo [3];  // box edges before move
    logic signed [25:0] r_hi [3];
    logic [9:0]         r_rmin [3];
    logic [9:0]         r_rmax [3];
    logic               r_empty;
    logic [9:0]         r_idx [3];
    logic               r_scan_v;  // read data of previous address valid
    logic [9:0]         r_vidx [3];
    logic               r_rd;
    logic               r_scan_done;

    // ---------- move amount: v*ts rounded half away from zero ----------
    logic signed [23:0] vsel;
    logic signed [41:0] prod;
    logic [41:0]        mag;
    logic [41:0]        rmag;
    always_comb begin
        vsel = r_vel[i_cmd.axis];
        prod = 42'(vsel) * $signed({1'b0, r_ts});
        mag  = prod[41] ? 42'(-prod) : prod;
        rmag = (mag + 42'd32768) >> 16;
    end

    // ---------- voxel range of moved box ----------
    logic signed [25:0] elo [3];
    logic signed [25:0] ehi [3];
    logic signed [42:0] mlo [3];
    logic signed [42:0] mhi [3];
    logic signed [34:0] vmin [3];
    logic signed [34:0] vmax [3];
    logic [9:0]         cmin [3];
    logic [9:0]         cmax [3];
    logic               emp [3];
    logic [10:0]        lim [3];
    logic signed [34:0] slim [3];
    always_comb begin
        lim[0] = 11'(1 << GX);
        lim[1] = 11'(1 << GY);
        lim[2] = 11'(1 << GZ);
        for (int k = 0; k < 3; k++) begin
            slim[k] = 35'(lim[k]);
            if (k == 1) begin
                elo[k] = 26'(r_pos[1]);
                ehi[k] = 26'(r_pos[1]) + $signed({15'd0, i_box_height});
            end else begin
                elo[k] = 26'(r_pos[k]) - $signed({17'd0, i_box_width[9:1]});
                ehi[k] = elo[k] + $signed({16'd0, i_box_width});
            end
            mlo[k] = 43'(elo[k]);
            mhi[k] = 43'(ehi[k]);
            if (k == int'(i_cmd.axis)) begin
                mlo[k] = mlo[k] + 43'(r_amt);
                mhi[k] = mhi[k] + 43'(r_amt);
            end
            vmin[k] = 35'(mlo[k] >>> 8);
            vmax[k] = 35'((mhi[k] - 43'sd1) >>> 8);
            cmin[k] = (vmin[k] < 0) ? 10'd0 : ((vmin[k] >= slim[k]) ? 10'(lim[k] - 1)
                                                                    : 10'(vmin[k]));
            cmax[k] = (vmax[k] >= slim[k]) ? 10'(lim[k] - 1)
                                           : ((vmax[k] < 0) ? 10'd0 : 10'(vmax[k]));
            emp[k]  = (vmax[k] < 0) || (vmin[k] >= slim[k]) || (vmin[k] > vmax[k]);
        end
    end

    // ---------- scan: order y, z, x (x innermost) ----------
    logic x_end, z_end, y_end;
    assign x_end = (r_idx[0] == r_rmax[0]);
    assign z_end = (r_idx[2] == r_rmax[2]);
    assign y_end = (r_idx[1] == r_rmax[1]);

    logic [AW-1:0] rd_addr, wr_addr;
    assign rd_addr = {r_idx[1][GY-1:0], r_idx[2][GZ-1:0], r_idx[0][GX-1:0]};
    assign wr_addr = {r_cin[1][GY-1:0], r_cin[2][GZ-1:0], r_cin[0][GX-1:0]};

    logic in_grid;
    assign in_grid = (r_cin[0] >= 0) && (r_cin[0] < 24'(1 << GX)) &&
                     (r_cin[1] >= 0) && (r_cin[1] < 24'(1 << GY)) &&
                     (r_cin[2] >= 0) && (r_cin[2] < 24'(1 << GZ));

    logic rd_bit;
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.do_write && in_grid) begin
            mem[wr_addr] <= r_solid_in;
        end
        rd_bit <= mem[rd_addr];
    end

    // candidate correction of visited voxel
    logic signed [41:0] cand;
    logic [1:0]         ax;
    always_comb begin
        ax = i_cmd.axis;
        if (!r_amt[41]) begin
            cand = $signed({24'd0, r_vidx[ax], 8'd0}) - 42'(r_hi[ax]);
        end else begin
            cand = $signed({24'd0, r_vidx[ax], 8'd0}) + 42'sd256 - 42'(r_lo[ax]);
        end
    end

    assign o_status.amt_zero    = (r_amt == '0);
    assign o_status.range_empty = r_empty;
    assign o_status.scan_last   = r_scan_done && !r_rd && r_scan_v == 1'b0;
    assign o_status.clr_last    = (r_clr_addr == AW'(DEPTH - 1));

    logic signed [23:0] gvy;
    logic [31:0]        dv;
    assign dv  = (32'(i_gravity_accel) * 32'(r_ts) + 32'd32768) >> 16;
    assign gvy = sat24(42'(r_vel[1]) - 42'(dv));

    logic signed [41:0] npos;
    assign npos = 42'(r_pos[i_cmd.axis]) + r_corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0]   <= '0;
            r_pos[1]   <= 24'sd7680;
            r_pos[2]   <= '0;
            r_grounded <= 1'b0;
            r_clr_addr <= '0;
            r_scan_done <= 1'b0;
            r_rd        <= 1'b0;
            r_scan_v    <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd.load) begin
                r_cin[0]   <= i_coord_x;
                r_cin[1]   <= i_coord_y;
                r_cin[2]   <= i_coord_z;
                r_solid_in <= i_solid;
                r_ts       <= i_time_step;
                r_clr_g    <= i_clear_ground;
                r_vel[0]   <= (i_action == ACT_TICK) ? i_vel_in_x : 24'sd0;
                r_vel[1]   <= (i_action == ACT_TICK) ? i_vel_in_y : 24'sd0;
                r_vel[2]   <= (i_action == ACT_TICK) ? i_vel_in_z : 24'sd0;
            end
            if (i_cmd.do_set) begin
                r_pos[0] <= r_cin[0];
                r_pos[1] <= r_cin[1];
                r_pos[2] <= r_cin[2];
            end
            if (i_cmd.grav) begin
                if (r_clr_g) r_grounded <= 1'b0;
                if (i_gravity_on) r_vel[1] <= gvy;
            end
            if (i_cmd.amt) begin
                r_amt <= prod[41] ? 42'(-rmag) : rmag;
            end
            if (i_cmd.range) begin
                for (int k = 0; k < 3; k++) begin
                    r_lo[k]   <= elo[k];
                    r_hi[k]   <= ehi[k];
                    r_rmin[k] <= cmin[k];
                    r_rmax[k] <= cmax[k];
                end
                r_empty <= emp[0] || emp[1] || emp[2];
            end
            if (i_cmd.scan_init) begin
                for (int k = 0; k < 3; k++) r_idx[k] <= r_rmin[k];
                r_corr      <= r_amt;
                r_hit       <= 1'b0;
                r_rd        <= !r_empty;
                r_scan_v    <= 1'b0;
                r_scan_done <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                // address issue
                r_scan_v <= r_rd;
                if (r_rd) begin
                    for (int k = 0; k < 3; k++) r_vidx[k] <= r_idx[k];
                    if (!x_end) begin
                        r_idx[0] <= r_idx[0] + 10'd1;
                    end else begin
                        r_idx[0] <= r_rmin[0];
                        if (!z_end) begin
                            r_idx[2] <= r_idx[2] + 10'd1;
                        end else begin
                            r_idx[2] <= r_rmin[2];
                            if (!y_end) begin
                                r_idx[1] <= r_idx[1] + 10'd1;
                            end else begin
                                r_rd        <= 1'b0;
                                r_scan_done <= 1'b1;
                            end
                        end
                    end
                end
                // data of previous address
                if (r_scan_v && rd_bit) begin
                    r_hit <= 1'b1;
                    if (!r_amt[41]) begin
                        if (cand < r_corr) r_corr <= cand;
                    end else begin
                        if (cand > r_corr) r_corr <= cand;
                    end
                end
            end
            if (i_cmd.commit) begin
                r_pos[i_cmd.axis] <= sat24(npos);
                if (i_cmd.axis == 2'd1) begin
                    if (r_amt[41] && r_corr > r_amt) begin
                        r_vel[1]   <= '0;
                        r_grounded <= 1'b1;
                    end else if (!r_amt[41] && r_corr < r_amt) begin
                        r_vel[1] <= '0;
                    end
                end else if (r_hit) begin
                    r_vel[i_cmd.axis] <= '0;
                end
            end
        end
    end

    assign o_pos_x     = r_pos[0];
    assign o_pos_y     = r_pos[1];
    assign o_pos_z     = r_pos[2];
    assign o_vel_out_x = r_vel[0];
    assign o_vel_out_y = r_vel[1];
    assign o_vel_out_z = r_vel[2];
    assign o_on_ground = r_grounded;

    a_empty_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_empty) |-> !r_hit)
        else $error("hit on empty range");
    a_corr_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_amt[41]) |-> (r_corr <= r_amt))
        else $error("positive move lengthened");
    a_corr_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_amt[41]) |-> (r_corr >= r_amt))
        else $error("negative move lengthened");

endmodule

// File: bench/voxel_aabb_collision_step_test.sv
`timescale 1ns / 100ps

module voxel_aabb_collision_step_test;
    import vacs_pkg::*;

    localparam int XB = 6, YB = 6, ZB = 6;
    localparam int GX = 1 << XB, GY = 1 << YB, GZ = 1 << ZB;
    // reset sweep of the occupancy store plus generous slack
    localparam int STALL_LIMIT = 1000000;

    typedef struct {
        logic [1:0]         action;
        logic signed [23:0] cx, cy, cz;
        logic               solid;
        logic signed [23:0] vx, vy, vz;
        logic [15:0]        ts;
        logic               clr;
    } t_item;

    typedef struct {
        logic signed [23:0] px, py, pz, vx, vy, vz;
        logic               og;
    } t_state_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action = '0;
    logic signed [23:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic               i_solid = 1'b0;
    logic signed [23:0] i_vel_in_x = '0, i_vel_in_y = '0, i_vel_in_z = '0;
    logic [15:0]        i_time_step = '0;
    logic               i_clear_ground = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [23:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [23:0] o_vel_out_x, o_vel_out_y, o_vel_out_z;
    logic               o_on_ground;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    voxel_aabb_collision_step #(.GRID_X_BITS(XB), .GRID_Y_BITS(YB), .GRID_Z_BITS(ZB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_coord_z(i_coord_z), .i_solid(i_solid), .i_vel_in_x(i_vel_in_x),
        .i_vel_in_y(i_vel_in_y), .i_vel_in_z(i_vel_in_z), .i_time_step(i_time_step),
        .i_clear_ground(i_clear_ground),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_vel_out_x(o_vel_out_x), .o_vel_out_y(o_vel_out_y), .o_vel_out_z(o_vel_out_z),
        .o_on_ground(o_on_ground),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_item      pending_items[$];
    t_state_out expected_states[$];
    int         mismatches = 0;
    int         send_idle_pct = 0, recv_stall_pct = 0;
    logic       item_xfer = 1'b0, cfg_xfer = 1'b0;
    int         quiet_cycles = 0;

    // shadow of the block's state and registers
    bit          occ[0:GX*GY*GZ-1];
    longint      box_pos[3];
    bit          grounded;
    int unsigned box_w = 154, box_h = 461, grav_acc = 8192;
    bit          grav_en = 1'b1;

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic int grid_size(int ax);
        return ax == 0 ? GX : (ax == 1 ? GY : GZ);
    endfunction

    function automatic bit solid_at(longint x, longint y, longint z);
        if (x < 0 || x >= GX || y < 0 || y >= GY || z < 0 || z >= GZ) return 1'b0;
        return occ[(y << (XB + ZB)) | (z << XB) | x];
    endfunction

    function automatic longint scaled_move(longint v, longint ts);
        longint p, r;
        p = v * ts;
        r = ((p < 0 ? -p : p) + 32768) >>> 16;
        return p < 0 ? -r : r;
    endfunction

    // clip a move of a along axis ax against the solid voxels the moved box overlaps
    function automatic longint clip_move(int ax, longint a, output bit hit);
        longint lo[3], hi[3], rlo[3], rhi[3], c, corr;
        corr = a;
        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (k == 1) begin
                lo[k] = box_pos[1];
                hi[k] = lo[k] + box_h;
            end else begin
                lo[k] = box_pos[k] - (box_w >> 1);
                hi[k] = lo[k] + box_w;
            end
            if (k == ax) begin
                lo[k] += a;
                hi[k] += a;
            end
            rlo[k] = lo[k] >>> 8;
            rhi[k] = (hi[k] - 1) >>> 8;
            if (rlo[k] < 0) rlo[k] = 0;
            if (rhi[k] > grid_size(k) - 1) rhi[k] = grid_size(k) - 1;
            if (rlo[k] > rhi[k]) return a;
        end
        for (longint y = rlo[1]; y <= rhi[1]; y++)
            for (longint z = rlo[2]; z <= rhi[2]; z++)
                for (longint x = rlo[0]; x <= rhi[0]; x++) begin
                    longint idx[3];
                    idx[0] = x; idx[1] = y; idx[2] = z;
                    if (solid_at(x, y, z)) begin
                        hit = 1'b1;
                        if (a > 0) begin
                            c = 256 * idx[ax] - (hi[ax] - a);
                            if (c < corr) corr = c;
                        end else begin
                            c = 256 * (idx[ax] + 1) - (lo[ax] - a);
                            if (c > corr) corr = c;
                        end
                    end
                end
        return corr;
    endfunction

    task automatic apply_item(input t_item it);
        longint     vel[3], a, corr, dv;
        bit         hit;
        t_state_out r;
        vel[0] = 0; vel[1] = 0; vel[2] = 0;
        case (it.action)
            ACT_WRITE: begin
                if (it.cx >= 0 && it.cx < GX && it.cy >= 0 && it.cy < GY &&
                    it.cz >= 0 && it.cz < GZ)
                    occ[(longint'(it.cy) << (XB + ZB)) | (longint'(it.cz) << XB) |
                        longint'(it.cx)] = it.solid;
            end
            ACT_SET: begin
                box_pos[0] = it.cx; box_pos[1] = it.cy; box_pos[2] = it.cz;
            end
            ACT_TICK: begin
                vel[0] = it.vx; vel[1] = it.vy; vel[2] = it.vz;
                if (it.clr) grounded = 1'b0;
                if (grav_en) begin
                    dv = (longint'(grav_acc) * it.ts + 32768) >>> 16;
                    vel[1] = clamp24(vel[1] - dv);
                end
                for (int k = 0; k < 3; k++) begin
                    a = scaled_move(vel[k], it.ts);
                    if (a != 0) begin
                        corr = clip_move(k, a, hit);
                        box_pos[k] = clamp24(box_pos[k] + corr);
                        if (k == 1) begin
                            if (a < 0 && corr > a) begin
                                vel[1] = 0;
                                grounded = 1'b1;
                            end else if (a > 0 && corr < a) begin
                                vel[1] = 0;
                            end
                        end else if (hit) begin
                            vel[k] = 0;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.px = 24'(box_pos[0]); r.py = 24'(box_pos[1]); r.pz = 24'(box_pos[2]);
        r.vx = 24'(vel[0]); r.vy = 24'(vel[1]); r.vz = 24'(vel[2]);
        r.og = grounded;
        expected_states.insert(expected_states.size(), r);
    endtask

    // sender: payload changes only at the falling edge after a transfer or while idle
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || item_xfer)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                t_item it;
                it = pending_items.pop_front();
                i_action <= it.action;
                i_coord_x <= it.cx; i_coord_y <= it.cy; i_coord_z <= it.cz;
                i_solid <= it.solid;
                i_vel_in_x <= it.vx; i_vel_in_y <= it.vy; i_vel_in_z <= it.vz;
                i_time_step <= it.ts;
                i_clear_ground <= it.clr;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        item_xfer <= i_valid && o_ready;
        cfg_xfer <= i_cfg_valid && o_cfg_ready;
        if (i_valid && o_ready) begin
            t_item it;
            it.action = i_action;
            it.cx = i_coord_x; it.cy = i_coord_y; it.cz = i_coord_z;
            it.solid = i_solid;
            it.vx = i_vel_in_x; it.vy = i_vel_in_y; it.vz = i_vel_in_z;
            it.ts = i_time_step;
            it.clr = i_clear_ground;
            apply_item(it);
        end
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_BOX_WIDTH:  box_w = i_cfg_data[9:0];
                REG_BOX_HEIGHT: box_h = i_cfg_data[10:0];
                REG_GRAV_ACCEL: grav_acc = i_cfg_data;
                REG_GRAV_ON:    grav_en = i_cfg_data[0];
                default: ;
            endcase
        end
        if (o_valid && i_ready) begin
            if (expected_states.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end else begin
                t_state_out e;
                e = expected_states.pop_front();
                if (o_pos_x !== e.px || o_pos_y !== e.py || o_pos_z !== e.pz ||
                    o_vel_out_x !== e.vx || o_vel_out_y !== e.vy ||
                    o_vel_out_z !== e.vz || o_on_ground !== e.og) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp pos %0d %0d %0d vel %0d %0d %0d g %0b,",
                                 e.px, e.py, e.pz, e.vx, e.vy, e.vz, e.og,
                                 " got pos %0d %0d %0d vel %0d %0d %0d g %0b",
                                 o_pos_x, o_pos_y, o_pos_z, o_vel_out_x, o_vel_out_y,
                                 o_vel_out_z, o_on_ground);
                end
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("voxel_aabb_collision_step test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        while (!cfg_xfer) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_states.size() != 0)
            @(negedge i_clk);
        // quiet time before the next phase
        repeat (40) @(negedge i_clk);
    endtask

    task automatic push(input logic [1:0] act, input int x, input int y, input int z,
                        input bit s, input int vx, input int vy, input int vz,
                        input int ts, input bit clr);
        t_item it;
        it.action = act; it.cx = 24'(x); it.cy = 24'(y); it.cz = 24'(z); it.solid = s;
        it.vx = 24'(vx); it.vy = 24'(vy); it.vz = 24'(vz); it.ts = 16'(ts); it.clr = clr;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic int rnd24();
        return int'($signed(24'($urandom())));
    endfunction

    task automatic push_random();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            push(ACT_WRITE, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                 $urandom_range(3) != 0, rnd24(), rnd24(), rnd24(), $urandom(),
                 1'($urandom()));
        end else if (pick < 23) begin
            push(ACT_SET, $urandom_range(16 * 256), $urandom_range(16 * 256),
                 $urandom_range(16 * 256), 1'($urandom()), rnd24(), rnd24(), rnd24(),
                 $urandom(), 1'($urandom()));
        end else if (pick < 90) begin
            push(ACT_TICK, rnd24(), rnd24(), rnd24(), 1'($urandom()),
                 $urandom_range(6000) - 3000, $urandom_range(6000) - 3000,
                 $urandom_range(6000) - 3000, $urandom_range(12000),
                 $urandom_range(7) == 0);
        end else begin
            // noise: any action, any field value
            push(2'($urandom()), rnd24(), rnd24(), rnd24(), 1'($urandom()), rnd24(),
                 rnd24(), rnd24(), $urandom(), 1'($urandom()));
        end
    endtask

    initial begin
        int cfg_w[4], cfg_h[4], cfg_g[4], cfg_on[4], idle_s[4], idle_r[4];
        for (int i = 0; i < GX * GY * GZ; i++) occ[i] = 1'b0;
        box_pos[0] = 0; box_pos[1] = 7680; box_pos[2] = 0;
        grounded = 1'b0;
        cfg_w  = '{154, 1, 512, 0};
        cfg_h  = '{461, 1, 1024, 0};
        cfg_g  = '{8192, 65535, 0, 0};
        cfg_on = '{1, 1, 0, 1};
        idle_s = '{0, 52, 0, 27};
        idle_r = '{0, 0, 52, 27};
        cfg_w[3] = $urandom_range(1, 512);
        cfg_h[3] = $urandom_range(1, 1024);
        cfg_g[3] = $urandom_range(65535);
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_BOX_WIDTH, 16'(cfg_w[ph]));
            write_reg(REG_BOX_HEIGHT, 16'(cfg_h[ph]));
            write_reg(REG_GRAV_ACCEL, 16'(cfg_g[ph]));
            write_reg(REG_GRAV_ON, 16'(cfg_on[ph]));
            send_idle_pct = idle_s[ph];
            recv_stall_pct = idle_r[ph];
            if (ph == 0) begin
                push(ACT_WRITE, 0, 0, 0, 1, 0, 0, 0, 0, 0);
                push(ACT_WRITE, GX - 1, GY - 1, GZ - 1, 1, 0, 0, 0, 0, 0);
                push(ACT_WRITE, -8388608, 8388607, GZ, 1, 0, 0, 0, 0, 0);
                push(ACT_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                push(ACT_SET, 8388607, -8388608, 8388607, 0, 0, 0, 0, 0, 0);
                push(ACT_TICK, 0, 0, 0, 0, 8388607, 8388607, 8388607, 65535, 1);
                push(ACT_TICK, 0, 0, 0, 0, -8388608, -8388608, -8388608, 65535, 0);
                push(2'd3, 1, 2, 3, 1, 5, 5, 5, 100, 1);
                // standing on a floor voxel: landing
                push(ACT_SET, 5 * 256 + 128, 10 * 256, 5 * 256 + 128, 0, 0, 0, 0, 0, 0);
                push(ACT_WRITE, 5, 8, 5, 1, 0, 0, 0, 0, 0);
                push(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 65535, 0);
                // wall beside the box blocks x, jump up into a ceiling
                push(ACT_WRITE, 6, 9, 5, 1, 0, 0, 0, 0, 0);
                push(ACT_TICK, 0, 0, 0, 0, 3000, 0, 0, 20000, 0);
                push(ACT_WRITE, 5, 12, 5, 1, 0, 0, 0, 0, 0);
                push(ACT_TICK, 0, 0, 0, 0, 0, 40000, 0, 20000, 1);
                push(ACT_TICK, 0, 0, 0, 0, 1000, 1000, -1000, 0, 0);
                push(ACT_WRITE, 5, 9, 4, 1, 0, 0, 0, 0, 0);
                push(ACT_TICK, 0, 0, 0, 0, 0, 0, -3000, 20000, 0);
                push(ACT_TICK, 0, 0, 0, 0, 1, -1, 1, 1, 0);
            end
            for (int n = 0; n < 55; n++) push_random();
            // no new items are queued until all results are in
            drain();
            for (int n = 0; n < 55; n++) push_random();
            drain();
        end

        if (mismatches == 0 && expected_states.size() == 0) begin
            $display("voxel_aabb_collision_step test passed");
        end else begin
            $display("voxel_aabb_collision_step test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/vacs_pkg.sv
rtl/vacs_ctrl.sv
rtl/vacs_dp.sv
rtl/voxel_aabb_collision_step.sv
bench/voxel_aabb_collision_step_test.sv
